// ===== design/chi_pkg.sv =====
// Shared widths, codes, payload types and control structs for the chained hash table.
package chi_pkg;

    // Fixed field widths of the request and result channels.
    localparam int ACTION_W = 2;
    localparam int KEY_W    = 32;
    localparam int BUCKET_W = 6;
    localparam int SLOT_W   = 4;
    localparam int NUMB_W   = 7;

    // Default table geometry.
    localparam int DEF_BUCKETS  = 64;
    localparam int DEF_SLOTS    = 16;
    localparam int DEF_KEY_BITS = 32;

    // Largest value the bucket count register can hold.
    localparam int NUM_BUCKETS_MAX = (1 << NUMB_W) - 1;

    localparam logic [NUMB_W-1:0] NUM_BUCKETS_RESET = NUMB_W'(64);

    // Configuration port.
    localparam int APB_DATA_W = 32;
    localparam int PADDR_W    = 3;
    localparam logic REG_NUM_BUCKETS = 1'b0;

    // Request actions.
    localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_READ   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd2;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [KEY_W-1:0]    key;
        logic [BUCKET_W-1:0] read_bucket;
        logic [SLOT_W-1:0]   read_slot;
    } in_item_t;

    typedef struct packed {
        logic [BUCKET_W-1:0] bucket;
        logic [SLOT_W-1:0]   slot;
        logic [KEY_W-1:0]    stored_key;
        logic                valid_res;
        logic                full_res;
    } out_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch_in;
        logic div_step;
        logic ins_commit;
        logic rd_commit;
        logic clr_write;
        logic load_out;
    } chi_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [ACTION_W-1:0] in_action;
        logic                div_done;
        logic                clr_last;
        logic                out_free;
    } chi_sts_t;

endpackage

// ===== design/chained_hash_insert.sv =====
// Top level of the chained hash table: configuration register, controller and datapath.
//
// Usage: requests enter on the s_ channel (valid/ready) as one in_item_t; every
// request produces exactly one out_item_t on the m_ channel (valid/ready).
// An insert hashes the key to bucket = key mod num_buckets (zero acting as one,
// values above BUCKETS capped) and stores it in the next free slot of that bucket;
// a read returns the key at a bucket and slot; a clear empties every bucket.
// Steps from request to result: an insert runs the bit-serial remainder divider
// over the key bits and then commits; a read passes through the registered reads
// of the fill count and key memories; a clear resets one fill count per cycle
// across all buckets. One request is in work at a time: the next is taken only
// after the result of the last has moved to the output register.
// Reset: aresetn is synchronous and active low. After reset the block sweeps the
// fill count memory across all BUCKETS entries with s_ready low; configuration
// writes are taken during that sweep. num_buckets resets to 64.
// Stall: a finished result waits in the output register until m_ready; the
// block still takes the next request meanwhile, and holds that request's result
// internally until the output register frees up.
module chained_hash_insert import chi_pkg::*; #(
    parameter int BUCKETS  = DEF_BUCKETS,
    parameter int SLOTS    = DEF_SLOTS,
    parameter int KEY_BITS = DEF_KEY_BITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Request channel.
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_data,
    // Result channel.
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data,
    // Configuration port.
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_W-1:0]    paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [NUMB_W-1:0] num_buckets_reg;
    chi_cmd_t          cmd;
    chi_sts_t          sts;

    // The bucket count register sits at byte address 0. The write lands in the
    // access phase; the low two address bits select bytes and are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_buckets_reg <= NUM_BUCKETS_RESET;
        end else if (psel && penable && pwrite && (paddr[2] == REG_NUM_BUCKETS)) begin
            num_buckets_reg <= pwdata[NUMB_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_NUM_BUCKETS) ? APB_DATA_W'(num_buckets_reg) : '0;

    chi_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    chi_dp #(
        .BUCKETS  (BUCKETS),
        .SLOTS    (SLOTS),
        .KEY_BITS (KEY_BITS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_data      (s_data),
        .num_buckets (num_buckets_reg),
        .cmd         (cmd),
        .sts         (sts),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

`ifndef NO_ASSERTIONS
    // Only one request is worked on at a time: an accepted request closes the
    // request channel on the following cycle.
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request accepted while another is in work");
`endif

endmodule

// ===== design/chi_ctrl.sv =====
// Sequencing state machine for the chained hash table.
module chi_ctrl import chi_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  chi_sts_t sts,
    output chi_cmd_t cmd
);

    typedef enum logic [7:0] {
        S_INIT  = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_DIV   = 8'b0000_0100,
        S_INS   = 8'b0000_1000,
        S_RWAIT = 8'b0001_0000,
        S_RCHK  = 8'b0010_0000,
        S_CLEAR = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            S_INIT: begin
                cmd.clr_write = 1'b1;
                if (sts.clr_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.latch_in = 1'b1;
                    case (sts.in_action)
                        ACT_INSERT: state_next = S_DIV;
                        ACT_READ:   state_next = S_RWAIT;
                        ACT_CLEAR:  state_next = S_CLEAR;
                        default:    state_next = S_DONE;
                    endcase
                end
            end
            S_DIV: begin
                if (sts.div_done) begin
                    state_next = S_INS;
                end else begin
                    cmd.div_step = 1'b1;
                end
            end
            S_INS: begin
                cmd.ins_commit = 1'b1;
                state_next     = S_DONE;
            end
            S_RWAIT: begin
                state_next = S_RCHK;
            end
            S_RCHK: begin
                cmd.rd_commit = 1'b1;
                state_next    = S_DONE;
            end
            S_CLEAR: begin
                cmd.clr_write = 1'b1;
                if (sts.clr_last) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (sts.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_INIT;
            end
        endcase
    end

endmodule

// ===== design/chi_dp.sv =====
// Datapath: request registers, remainder divider, fill count and key memories, result register.
module chi_dp import chi_pkg::*; #(
    parameter int BUCKETS  = DEF_BUCKETS,
    parameter int SLOTS    = DEF_SLOTS,
    parameter int KEY_BITS = DEF_KEY_BITS
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  in_item_t          s_data,
    input  logic [NUMB_W-1:0] num_buckets,
    input  chi_cmd_t          cmd,
    output chi_sts_t          sts,
    output logic              m_valid,
    input  logic              m_ready,
    output out_item_t         m_data
);

    localparam int STORE_W = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
    localparam int BIDX_W  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int CNT_W   = $clog2(SLOTS + 1);
    localparam int DIV_MAX = (BUCKETS < NUM_BUCKETS_MAX) ? BUCKETS : NUM_BUCKETS_MAX;
    localparam int DIV_W   = $clog2(DIV_MAX + 1);
    localparam int DCNT_W  = $clog2(STORE_W + 1);
    localparam int DEPTH   = BUCKETS * SLOTS;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Request registers.
    logic [ACTION_W-1:0] act_reg;
    logic [STORE_W-1:0]  key_reg;
    logic [BUCKET_W-1:0] rb_reg;
    logic [SLOT_W-1:0]   rs_reg;

    // Restoring divider, one quotient bit per step; only the remainder is kept.
    logic [STORE_W-1:0] shift_reg;
    logic [STORE_W-1:0] shift_next;
    logic [DIV_W-1:0]   rem_reg;
    logic [DIV_W-1:0]   rem_next;
    logic [DIV_W-1:0]   div_reg;
    logic [DIV_W-1:0]   div_clamp;
    logic [DCNT_W-1:0]  dcnt_reg;
    logic [DIV_W:0]     trial;

    // Memories and their registered read data.
    logic [CNT_W-1:0]   fill_mem [DEPTH > 0 ? BUCKETS : 1];
    logic [STORE_W-1:0] key_mem  [DEPTH];
    logic [CNT_W-1:0]   fill_q_reg;
    logic [STORE_W-1:0] kq_reg;

    logic [BIDX_W-1:0]  clr_cnt_reg;
    logic [BIDX_W-1:0]  bidx_ins;
    logic [BIDX_W-1:0]  bidx_rd;
    logic [BIDX_W-1:0]  fill_raddr;
    logic [BIDX_W-1:0]  fill_waddr;
    logic [CNT_W-1:0]   fill_wdata;
    logic               fill_we;
    logic [ADDR_W-1:0]  kw_addr;
    logic [ADDR_W-1:0]  kr_addr;
    logic               ins_full;
    logic               rd_ok;

    out_item_t res_reg;
    out_item_t m_data_reg;
    logic      m_valid_reg;

    // A bucket count of zero acts as one; anything above the table size is capped.
    always_comb begin
        if (num_buckets == '0) begin
            div_clamp = DIV_W'(1);
        end else if (int'(num_buckets) > BUCKETS) begin
            div_clamp = DIV_W'(BUCKETS);
        end else begin
            div_clamp = DIV_W'(num_buckets);
        end
    end

    always_comb begin
        trial      = {rem_reg, shift_reg[STORE_W-1]};
        shift_next = shift_reg << 1;
        if (trial >= {1'b0, div_reg}) begin
            rem_next = DIV_W'(trial - {1'b0, div_reg});
        end else begin
            rem_next = DIV_W'(trial);
        end
    end

    assign bidx_ins   = BIDX_W'(rem_reg);
    assign bidx_rd    = BIDX_W'(rb_reg);
    assign fill_raddr = (act_reg == ACT_READ) ? bidx_rd : bidx_ins;
    assign ins_full   = int'(fill_q_reg) >= SLOTS;
    assign rd_ok      = (int'(rb_reg) < BUCKETS) && (int'(rs_reg) < int'(fill_q_reg));
    assign kw_addr    = ADDR_W'(bidx_ins) * ADDR_W'(SLOTS) + ADDR_W'(fill_q_reg);
    assign kr_addr    = ADDR_W'(bidx_rd) * ADDR_W'(SLOTS) + ADDR_W'(rs_reg);

    assign fill_we    = cmd.clr_write || (cmd.ins_commit && !ins_full);
    assign fill_waddr = cmd.clr_write ? clr_cnt_reg : bidx_ins;
    assign fill_wdata = cmd.clr_write ? '0 : CNT_W'(fill_q_reg + 1'b1);

    always_ff @(posedge aclk) begin
        fill_q_reg <= fill_mem[fill_raddr];
        if (fill_we) begin
            fill_mem[fill_waddr] <= fill_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        kq_reg <= key_mem[kr_addr];
        if (cmd.ins_commit && !ins_full) begin
            key_mem[kw_addr] <= key_reg;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (cmd.latch_in) begin
            act_reg   <= s_data.action;
            key_reg   <= STORE_W'(s_data.key);
            shift_reg <= STORE_W'(s_data.key);
            rb_reg    <= s_data.read_bucket;
            rs_reg    <= s_data.read_slot;
            rem_reg   <= '0;
            div_reg   <= div_clamp;
            res_reg   <= '0;
        end else begin
            if (cmd.div_step) begin
                shift_reg <= shift_next;
                rem_reg   <= rem_next;
            end
            if (cmd.ins_commit) begin
                res_reg.bucket <= BUCKET_W'(rem_reg);
                if (ins_full) begin
                    res_reg.slot       <= '0;
                    res_reg.stored_key <= '0;
                    res_reg.valid_res  <= 1'b0;
                    res_reg.full_res   <= 1'b1;
                end else begin
                    res_reg.slot       <= SLOT_W'(fill_q_reg);
                    res_reg.stored_key <= KEY_W'(key_reg);
                    res_reg.valid_res  <= 1'b1;
                    res_reg.full_res   <= 1'b0;
                end
            end
            if (cmd.rd_commit) begin
                res_reg.bucket     <= rb_reg;
                res_reg.slot       <= rs_reg;
                res_reg.stored_key <= rd_ok ? KEY_W'(kq_reg) : '0;
                res_reg.valid_res  <= rd_ok;
                res_reg.full_res   <= 1'b0;
            end
        end
        if (cmd.load_out) begin
            m_data_reg <= res_reg;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dcnt_reg    <= '0;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.latch_in) begin
                dcnt_reg <= '0;
            end else if (cmd.div_step) begin
                dcnt_reg <= dcnt_reg + 1'b1;
            end
            if (cmd.clr_write) begin
                clr_cnt_reg <= sts.clr_last ? '0 : clr_cnt_reg + 1'b1;
            end
            if (cmd.load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.in_action = s_data.action;
    assign sts.div_done  = dcnt_reg == DCNT_W'(STORE_W);
    assign sts.clr_last  = clr_cnt_reg == BIDX_W'(BUCKETS - 1);
    assign sts.out_free  = !m_valid_reg || m_ready;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef NO_ASSERTIONS
    // The partial remainder must stay below the divisor throughout the division.
    a_rem_below_div: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_step |-> rem_reg < div_reg)
        else $error("remainder reached the divisor");

    // A result must never overwrite one that has not been taken.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> !(m_valid_reg && !m_ready))
        else $error("result register overwritten");

    // A stored insert and a full bucket cannot be reported together.
    a_valid_full_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(m_data_reg.valid_res && m_data_reg.full_res))
        else $error("valid and full both set");
`endif

endmodule

// ===== verif/chained_hash_insert_tb.sv =====
// Self-checking testbench for the chained hash table: scoreboard, drivers and test sequence.
module chained_hash_insert_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import chi_pkg::*;

    localparam int TABLE_BUCKETS = DEF_BUCKETS;
    localparam int TABLE_SLOTS   = DEF_SLOTS;
    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 10;
    localparam int CYCLE_LIMIT   = 1_000_000;
    // A clear is the longest request; this covers it with margin.
    localparam int DRAIN_CYCLES  = 100;
    localparam int SEGMENTS      = 12;
    localparam int SEG_ITEMS     = 150;

    // The package names three actions; the fourth code is accepted and does nothing.
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    // Scoreboard: keeps its own copy of the table, predicts the result of every
    // accepted request and checks the results in order.
    class chain_table_sb;
        logic [4:0]         bucket_fill [TABLE_BUCKETS];
        logic [KEY_W-1:0]   slot_keys [TABLE_BUCKETS*TABLE_SLOTS];
        logic [NUMB_W-1:0]  num_buckets;
        out_item_t          pending_results [$];
        int unsigned        mismatches;
        int unsigned        inserts_stored;
        int unsigned        inserts_full;
        int unsigned        read_hits;
        int unsigned        read_misses;
        int unsigned        clears;

        function new();
            foreach (bucket_fill[i]) bucket_fill[i] = '0;
            num_buckets    = NUM_BUCKETS_RESET;
            mismatches     = 0;
            inserts_stored = 0;
            inserts_full   = 0;
            read_hits      = 0;
            read_misses    = 0;
            clears         = 0;
        endfunction

        // Bucket count actually used for the modulo.
        function int unsigned hash_divisor();
            if (num_buckets == 0) return 1;
            if (num_buckets > TABLE_BUCKETS) return TABLE_BUCKETS;
            return num_buckets;
        endfunction

        function void note_request(in_item_t req);
            out_item_t   res;
            int unsigned b;
            int unsigned n;
            res = '0;
            case (req.action)
                ACT_INSERT: begin
                    b = req.key % hash_divisor();
                    n = bucket_fill[b];
                    res.bucket = BUCKET_W'(b);
                    if (n >= TABLE_SLOTS) begin
                        res.full_res = 1'b1;
                        inserts_full++;
                    end else begin
                        slot_keys[b*TABLE_SLOTS + n] = req.key;
                        bucket_fill[b] = 5'(n + 1);
                        res.slot       = SLOT_W'(n);
                        res.stored_key = req.key;
                        res.valid_res  = 1'b1;
                        inserts_stored++;
                    end
                end
                ACT_READ: begin
                    res.bucket = req.read_bucket;
                    res.slot   = req.read_slot;
                    if (req.read_slot < bucket_fill[req.read_bucket]) begin
                        res.stored_key =
                            slot_keys[req.read_bucket*TABLE_SLOTS + req.read_slot];
                        res.valid_res  = 1'b1;
                        read_hits++;
                    end else begin
                        read_misses++;
                    end
                end
                ACT_CLEAR: begin
                    foreach (bucket_fill[i]) bucket_fill[i] = '0;
                    clears++;
                end
                default: ;
            endcase
            pending_results.push_back(res);
        endfunction

        function void compare_field(string field, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                $error("%s: expected %0h, got %0h", field, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (pending_results.size() == 0) begin
                $error("result with no request waiting: %p", got);
                mismatches++;
                return;
            end
            want = pending_results.pop_front();
            compare_field("bucket", want.bucket, got.bucket);
            compare_field("slot", want.slot, got.slot);
            compare_field("stored_key", want.stored_key, got.stored_key);
            compare_field("valid_res", want.valid_res, got.valid_res);
            compare_field("full_res", want.full_res, got.full_res);
        endfunction
    endclass

    bit                    aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    in_item_t              s_data;
    logic                  m_valid;
    logic                  m_ready;
    out_item_t             m_data;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [PADDR_W-1:0]    paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    chain_table_sb sb;
    int unsigned   cycles;
    int unsigned   accepted_cnt;
    int unsigned   settings_used;
    int unsigned   snd_idle_pct;
    int unsigned   rcv_idle_pct;

    chained_hash_insert dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        forever #(CLK_HALF) aclk = ~aclk;
    end

    // Handshake monitor. It runs at the rising edge, before the design's registers
    // update, so it sees exactly what the design sees. It also guards the run
    // against a hang.
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("end of test: mismatches");
            $finish;
        end else if (aresetn === 1'b1) begin
            if (s_valid && s_ready === 1'b1) begin
                sb.note_request(s_data);
                accepted_cnt++;
            end
            if (m_valid === 1'b1 && m_ready) begin
                sb.check_result(m_data);
            end
        end
    end

    // The receiver stalls at random. Its rate changes from phase to phase.
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= rcv_idle_pct);
    end

    function automatic in_item_t build_request(logic [ACTION_W-1:0] action,
                                               logic [KEY_W-1:0] key,
                                               logic [BUCKET_W-1:0] rb,
                                               logic [SLOT_W-1:0] rs);
        in_item_t req;
        req.action      = action;
        req.key         = key;
        req.read_bucket = rb;
        req.read_slot   = rs;
        return req;
    endfunction

    // Random request. Most requests are inserts, and reads of entries that are
    // really in the table, so that buckets fill up and the stored keys are read
    // back. The rest are reads outside the fill, unused actions and clears.
    function automatic in_item_t make_request(int unsigned used);
        in_item_t    req;
        int unsigned pick;
        int unsigned fill;
        req = build_request(ACT_INSERT, $urandom, BUCKET_W'($urandom), SLOT_W'($urandom));
        pick = $urandom_range(99);
        if (pick < 50) begin
            // Extreme keys now and then, and keys that crowd into a few buckets.
            if ($urandom_range(9) == 0) begin
                req.key = ($urandom_range(1) == 0) ? '0 : '1;
            end else if ($urandom_range(9) < 3) begin
                req.key[5:0] = 6'($urandom_range(3));
            end
        end else if (pick < 85) begin
            req.action      = ACT_READ;
            req.read_bucket = BUCKET_W'($urandom_range(used - 1));
            fill = sb.bucket_fill[req.read_bucket];
            if (fill > 0) req.read_slot = SLOT_W'($urandom_range(fill - 1));
        end else if (pick < 93) begin
            req.action = ACT_READ;
        end else if (pick < 97) begin
            req.action = ACT_UNUSED;
        end else begin
            req.action = ACT_CLEAR;
        end
        return req;
    endfunction

    // Offer one request and return at the falling edge after it was taken, with
    // valid still high, so the next call can either idle or present the next one.
    task automatic send_request(in_item_t req);
        int unsigned target;
        while ($urandom_range(99) < snd_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        target = accepted_cnt + 1;
        do @(negedge aclk); while (accepted_cnt < target);
    endtask

    // Hold off the sender until every predicted result has come back.
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (sb.pending_results.size() != 0) @(negedge aclk);
    endtask

    // Two-phase write of the bucket count register.
    task automatic write_num_buckets(logic [NUMB_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(4 * int'(REG_NUM_BUCKETS));
        pwdata  <= APB_DATA_W'(value);
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.num_buckets = value;
        settings_used++;
    endtask

    initial begin
        logic [NUMB_W-1:0] seg_setting [SEGMENTS];
        sb = new();
        cycles        = 0;
        accepted_cnt  = 0;
        settings_used = 0;
        snd_idle_pct  = 25;
        rcv_idle_pct  = 50;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        m_ready = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;

        // Extremes, the clamped values above 64, and a few random settings.
        seg_setting = '{7'd64, 7'd1, 7'd127, 7'd2, 7'd0, 7'd63,
                        7'd65, 7'd3, 7'd0, 7'd64, 7'd5, 7'd0};
        seg_setting[8]  = NUMB_W'($urandom_range(1, 64));
        seg_setting[11] = NUMB_W'($urandom);

        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part. A bucket count of zero acts as one, so every key lands in
        // bucket 0: sixteen inserts fill it and the seventeenth is dropped as full.
        // The write lands during the clearing sweep after reset.
        write_num_buckets(7'd0);
        for (int i = 0; i < TABLE_SLOTS + 1; i++) begin
            logic [KEY_W-1:0] k;
            case (i)
                0:       k = '0;
                1:       k = '1;
                2:       k = 32'h8000_0000;
                3:       k = 32'h0000_0001;
                default: k = $urandom;
            endcase
            send_request(build_request(ACT_INSERT, k, BUCKET_W'($urandom),
                                       SLOT_W'($urandom)));
        end
        send_request(build_request(ACT_READ, $urandom, 6'd0, 4'd0));
        send_request(build_request(ACT_READ, $urandom, 6'd0, 4'd15));
        // A read of an empty bucket at the top indexes is a miss.
        send_request(build_request(ACT_READ, $urandom, 6'd63, 4'd15));
        wait_drained();

        // A count above 64 acts as 64. The keys already stored stay readable.
        write_num_buckets(7'd127);
        send_request(build_request(ACT_READ, $urandom, 6'd0, 4'd3));
        send_request(build_request(ACT_INSERT, '1, 6'd0, 4'd0));
        send_request(build_request(ACT_READ, '0, 6'd63, 4'd0));
        send_request(build_request(ACT_UNUSED, '1, '1, '1));
        send_request(build_request(ACT_CLEAR, '1, '1, '1));
        send_request(build_request(ACT_READ, '0, 6'd0, 4'd0));
        wait_drained();

        // Random part: one bucket count per segment. The sender is the busier side
        // first, then the receiver, and the last segments run with no idling.
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            if (seg < SEGMENTS / 3) begin
                snd_idle_pct = 25;
                rcv_idle_pct = 50;
            end else if (seg < 2 * SEGMENTS / 3) begin
                snd_idle_pct = 50;
                rcv_idle_pct = 25;
            end else begin
                snd_idle_pct = 0;
                rcv_idle_pct = 0;
            end
            wait_drained();
            write_num_buckets(seg_setting[seg]);
            for (int i = 0; i < SEG_ITEMS; i++) begin
                // Now and then the sender waits for the table to go quiet.
                if ($urandom_range(199) == 0) wait_drained();
                send_request(make_request(sb.hash_divisor()));
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge aclk);

        $display("covered %0d stored inserts, %0d inserts into full buckets, %0d clears",
                 sb.inserts_stored, sb.inserts_full, sb.clears);
        $display("%0d read hits, %0d read misses, %0d bucket counts, %0d requests",
                 sb.read_hits, sb.read_misses, settings_used, accepted_cnt);
        if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ===== chained_hash_insert.f =====
design/chi_pkg.sv
design/chi_ctrl.sv
design/chi_dp.sv
design/chained_hash_insert.sv
verif/chained_hash_insert_tb.sv
